/* hw/rtl/lru_key_value_cache_core_assert.svh */
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared concurrent check forms used by the cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// expression holds at every clock edge out of reset
`define LKVC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("lkvc: invariant check failed");

// consequent holds in the same cycle as the antecedent
`define LKVC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lkvc: implication check failed");

// consequent holds in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lkvc: next-cycle check failed");

`endif

/* hw/rtl/lkvc_pkg.sv */
// ----------------------------------------------------------------------------
// lkvc_pkg
// types and constants shared by the lru key-value cache cells and top level
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int KEY_BITS   = 16;
   localparam int VALUE_BITS = 31;
   localparam int CAP_BITS   = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // register index as decoded from the word address
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef struct packed {
      logic                  cmd;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   // broadcast control from the sequencer to every cell
   typedef struct packed {
      logic lookup;
      logic update;
      logic hit;
      logic insert;
      logic evict;
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

/* hw/rtl/lkvc_cell.sv */
// ----------------------------------------------------------------------------
// lkvc_cell
// one slot of the recency-ordered entry chain: key compare, hit readout and
// move-down to the next less recent position
// ----------------------------------------------------------------------------
module lkvc_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  lkvc_pkg::cell_ctrl_type         ctrl,
   input  logic [lkvc_pkg::KEY_BITS-1:0]   cmp_key,
   input  lkvc_pkg::entry_type             prev,
   input  logic                            sfx_hit_in,
   input  logic [lkvc_pkg::VALUE_BITS-1:0] sfx_data_in,
   output lkvc_pkg::entry_type             entry_out,
   output logic                            sfx_hit_out,
   output logic [lkvc_pkg::VALUE_BITS-1:0] sfx_data_out,
   output logic                            match_out
);

   logic                            valid_ff, valid_in;
   logic                            match_ff, match_in;
   logic [lkvc_pkg::KEY_BITS-1:0]   key_ff, key_in;
   logic [lkvc_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                            shift;

   // hit flag and hit data collapse toward the most recent end
   assign sfx_hit_out  = sfx_hit_in | match_ff;
   assign sfx_data_out = sfx_data_in | (match_ff ? value_ff : '0);

   always_comb begin
      match_in = ctrl.lookup ? (valid_ff && (key_ff == cmp_key)) : match_ff;

      // this cell moves down when it lies at or above the slot being vacated
      if (ctrl.hit) begin
         shift = sfx_hit_out;
      end else if (ctrl.insert) begin
         shift = prev.valid;
      end else if (ctrl.evict) begin
         shift = valid_ff;
      end else begin
         shift = 1'b0;
      end
      shift = shift & ctrl.update;

      valid_in = shift ? prev.valid : valid_ff;
      key_in   = shift ? prev.key   : key_ff;
      value_in = shift ? prev.value : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign entry_out.valid = valid_ff;
   assign entry_out.key   = key_ff;
   assign entry_out.value = value_ff;
   assign match_out       = match_ff;

endmodule

/* hw/rtl/lru_key_value_cache_core.sv */
// Response: a get's result is registered once its transfer is accepted and has passed the lookup and update states.
// Flow: each item takes a compare step in the lookup state, then a chain update step in the update state; a new
//   item is taken as that update completes, which waits only while a finished get result is held by rsp_stall.
// Reset: synchronous; all entries become invalid, occupancy 0, capacity 16.
// No clearing pass: each cell has its own valid flip-flop.
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement,
// built as a chain of cells ordered from most to least recent
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_core_assert.svh"

module lru_key_value_cache_core #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lkvc_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lkvc_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lkvc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lkvc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lkvc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CNT_W = (OCC_W > lkvc_pkg::CAP_BITS) ? OCC_W : lkvc_pkg::CAP_BITS;

   lkvc_pkg::state_type             state_ff, state_in;
   lkvc_pkg::req_type               req_ff;
   logic [lkvc_pkg::CAP_BITS-1:0]   cap_ff, cap_in;
   logic [OCC_W-1:0]                occ_ff, occ_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::rsp_type               rsp_ff;
   lkvc_pkg::cell_ctrl_type         ctrl;
   lkvc_pkg::entry_type             new_ent;
   lkvc_pkg::entry_type             cell_ent [ENTRIES];
   logic                            sfx_hit [ENTRIES+1];
   logic [lkvc_pkg::VALUE_BITS-1:0] sfx_data [ENTRIES+1];
   logic [ENTRIES-1:0]              match_vec;
   logic [ENTRIES-1:0]              valid_vec;
   logic [ENTRIES-1:0]              occ_mask;
   logic [CNT_W-1:0]                eff_cap;
   logic                            is_get, is_put, has_room, go, accept, cfg_wr;

   // ---------------- configuration port
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (cfg_wr && (csr_paddr[2] == lkvc_pkg::REG_CAPACITY)) begin
         cap_in = csr_pwdata[lkvc_pkg::CAP_BITS-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == lkvc_pkg::REG_CAPACITY) begin
         csr_prdata[lkvc_pkg::CAP_BITS-1:0] = cap_ff;
      end
   end

   // capacity zero acts as one, anything above the chain length saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (CNT_W'(cap_ff) > CNT_W'(ENTRIES)) begin
         eff_cap = CNT_W'(ENTRIES);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   // ---------------- sequencer
   always_comb begin
      is_get   = (req_ff.cmd == lkvc_pkg::CMD_GET);
      is_put   = (req_ff.cmd == lkvc_pkg::CMD_PUT);
      has_room = CNT_W'(occ_ff) < eff_cap;
      go       = (state_ff == lkvc_pkg::ST_UPDATE) && (!is_get || !rsp_valid_ff || !rsp_stall);
      req_stall = !((state_ff == lkvc_pkg::ST_IDLE) || go);
      accept    = req_valid && !req_stall;

      case (state_ff)
         lkvc_pkg::ST_IDLE: begin
            state_in = accept ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
         end
         lkvc_pkg::ST_LOOKUP: begin
            state_in = lkvc_pkg::ST_UPDATE;
         end
         lkvc_pkg::ST_UPDATE: begin
            if (go) begin
               state_in = accept ? lkvc_pkg::ST_LOOKUP : lkvc_pkg::ST_IDLE;
            end else begin
               state_in = lkvc_pkg::ST_UPDATE;
            end
         end
         default: begin
            state_in = lkvc_pkg::ST_IDLE;
         end
      endcase

      ctrl.lookup = (state_ff == lkvc_pkg::ST_LOOKUP);
      ctrl.update = go;
      ctrl.hit    = sfx_hit[0];
      ctrl.insert = is_put && !sfx_hit[0] && has_room;
      ctrl.evict  = is_put && !sfx_hit[0] && !has_room;

      // front of the chain takes the request key, with the hit value on a get
      new_ent.valid = 1'b1;
      new_ent.key   = req_ff.key;
      new_ent.value = is_put ? req_ff.value : sfx_data[0];

      occ_in = (go && ctrl.insert) ? occ_ff + OCC_W'(1) : occ_ff;

      if (go && is_get) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkvc_pkg::ST_IDLE;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_payload;
      end
      if (go && is_get) begin
         rsp_ff.hit        <= sfx_hit[0];
         rsp_ff.read_value <= sfx_data[0];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- cell chain, index 0 is the most recent entry
   assign sfx_hit[ENTRIES]  = 1'b0;
   assign sfx_data[ENTRIES] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_pkg::entry_type prev_ent;

      if (i == 0) begin : g_head
         assign prev_ent = new_ent;
      end else begin : g_body
         assign prev_ent = cell_ent[i-1];
      end

      lkvc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .cmp_key      (req_ff.key),
         .prev         (prev_ent),
         .sfx_hit_in   (sfx_hit[i+1]),
         .sfx_data_in  (sfx_data[i+1]),
         .entry_out    (cell_ent[i]),
         .sfx_hit_out  (sfx_hit[i]),
         .sfx_data_out (sfx_data[i]),
         .match_out    (match_vec[i])
      );

      assign valid_vec[i] = cell_ent[i].valid;
      assign occ_mask[i]  = (OCC_W'(i) < occ_ff);
   end

   // ---------------- checks
   `LKVC_ASSERT_ALWAYS(a_valid_contiguous, clock, reset, valid_vec == occ_mask)
   `LKVC_ASSERT_IMPL(a_single_match, clock, reset, state_ff == lkvc_pkg::ST_UPDATE,
                     $onehot0(match_vec))
   `LKVC_ASSERT_NEXT(a_accept_to_lookup, clock, reset, accept,
                     state_ff == lkvc_pkg::ST_LOOKUP)
   `LKVC_ASSERT_IMPL(a_rsp_after_update, clock, reset, $rose(rsp_valid_ff),
                     $past(state_ff == lkvc_pkg::ST_UPDATE))
   `LKVC_ASSERT_NEXT(a_insert_grows, clock, reset, go && ctrl.insert,
                     occ_ff == $past(occ_ff) + OCC_W'(1))

endmodule
